@@ rtl/tsa_pkg.sv @@
// Shared types and constants of the three-axis sample averager.
package tsa_pkg;

	localparam int NUM_AXES        = 3;
	localparam int DEF_RING_DEPTH  = 10;
	localparam int DEF_SAMPLE_BITS = 10;
	localparam int VALUE_W         = 10;
	localparam int TICK_W          = 8;
	localparam int CHAN_W          = 2;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 10;

	localparam logic [TICK_W-1:0] TICK_LIMIT_RESET = 8'd100;
	localparam logic [VALUE_W-1:0] ALARM_THRESHOLD_RESET = 10'd0;

	// request kinds
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// channel codes
	localparam logic [CHAN_W-1:0] CH_X     = 2'd0;
	localparam logic [CHAN_W-1:0] CH_Y     = 2'd1;
	localparam logic [CHAN_W-1:0] CH_Z     = 2'd2;
	localparam logic [CHAN_W-1:0] CH_OTHER = 2'd3;

	// last step of the round-robin channel counter
	localparam logic [CHAN_W-1:0] LAST_STEP = CH_Z;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_TICK_LIMIT      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_THRESHOLD = 2'd1;

	typedef struct packed {
		logic               req_type;
		logic [CHAN_W-1:0]  sample_channel;
		logic [VALUE_W-1:0] sample_value;
	} req_item_t;

	typedef struct packed {
		logic               start_request;
		logic [CHAN_W-1:0]  start_channel;
		logic               avg_valid;
		logic [VALUE_W-1:0] avg_x;
		logic [VALUE_W-1:0] avg_y;
		logic [VALUE_W-1:0] avg_z;
		logic               calibrated;
		logic               below_alarm;
	} rsp_item_t;

endpackage

@@ rtl/three_axis_sample_averager_top.sv @@
// Top level of the three-axis sample averager.
//
// Usage: the req channel carries timer ticks and finished conversion samples,
// the rsp channel returns exactly one result item per request item, in order.
// A tick advances the tick counter; once it reaches tick_limit the result asks
// for a conversion on the channel named by the round-robin step counter.
// A sample on x, y or z replaces the oldest entry of that channel's ring and
// updates its running sum; every third sample refreshes the truncated means
// of all three rings and sets calibrated. Any sample below alarm_threshold
// flags below_alarm.
// The cfg channel writes tick_limit (index 0) and alarm_threshold (index 1);
// it is always ready and should be used only while no item is in flight.
// An accepted item passes through stage 1, stage 2 and the output register to rsp.
// Throughput: one item per cycle while rsp does not stall, set by the single
// read-modify-write of the ring memory (read at accept, written back from stage 1).
// Reset clears the rings (through per-entry valid bits), sums, means,
// counters and flags at once; no clearing pass is needed.
// When rsp stalls, the result holds in the output register, the two inner
// stages fill, and req_ready drops only once all three are occupied.
module three_axis_sample_averager_top #(
	parameter int RING_DEPTH  = tsa_pkg::DEF_RING_DEPTH,
	parameter int SAMPLE_BITS = tsa_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  tsa_pkg::req_item_t                  req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output tsa_pkg::rsp_item_t                  rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int NUM_ENTRIES = tsa_pkg::NUM_AXES * RING_DEPTH;
	localparam int ADDR_W      = $clog2(NUM_ENTRIES);
	localparam int POS_W       = $clog2(RING_DEPTH);
	localparam int SUM_W       = SAMPLE_BITS + POS_W;
	localparam int VALUE_W     = tsa_pkg::VALUE_W;
	localparam int CHAN_W      = tsa_pkg::CHAN_W;
	localparam int TICK_W      = tsa_pkg::TICK_W;
	// divide by RING_DEPTH as multiply by a rounded-up reciprocal, exact for all sums
	localparam int MUL_K       = SUM_W + POS_W;
	localparam int PROD_W      = 2 * SUM_W + 1;
	localparam logic [SUM_W:0] MUL_M =
		(SUM_W+1)'(((longint'(1) << MUL_K) + longint'(RING_DEPTH) - 1) / RING_DEPTH);
	localparam logic [VALUE_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= VALUE_W) ?
		{VALUE_W{1'b1}} : VALUE_W'((1 << SAMPLE_BITS) - 1);

	typedef struct packed {
		logic                   store;
		logic [CHAN_W-1:0]      axis;
		logic [ADDR_W-1:0]      addr;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   wrap;
		logic                   start_request;
		logic [CHAN_W-1:0]      start_channel;
		logic                   calibrated;
		logic                   below_alarm;
	} stage_t;

	// configuration
	logic [TICK_W-1:0]  tick_limit_q;
	logic [VALUE_W-1:0] alarm_threshold_q;

	// control state
	logic [TICK_W-1:0] tick_count_q;
	logic [CHAN_W-1:0] step_q;
	logic              calibrated_q;
	logic [POS_W-1:0]  pos_q [tsa_pkg::NUM_AXES];
	logic [SUM_W-1:0]  sum_q [tsa_pkg::NUM_AXES];
	logic [VALUE_W-1:0] mean_q [tsa_pkg::NUM_AXES];

	// pipeline
	logic               valid_s1, valid_s2, out_valid_q;
	stage_t             st_s1, st_s2, st_new;
	tsa_pkg::rsp_item_t rsp_q;

	logic req_accept, s1_free, s2_free, out_free, s1_adv, s2_adv;

	// accept-side decode
	logic               is_sample, is_store;
	logic [CHAN_W-1:0]  axis_new;
	logic [POS_W-1:0]   pos_cur;
	logic [VALUE_W-1:0] sample_masked;
	logic               tick_fire;

	// memory
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]       sum_upd;
	logic [PROD_W-1:0]      prod [tsa_pkg::NUM_AXES];
	logic [VALUE_W-1:0]     mean_new [tsa_pkg::NUM_AXES];

	// handshakes
	assign out_free   = !out_valid_q || rsp_ready;
	assign s2_free    = !valid_s2 || out_free;
	assign s1_free    = !valid_s1 || s2_free;
	assign s1_adv     = valid_s1 && s2_free;
	assign s2_adv     = valid_s2 && out_free;
	assign req_ready  = s1_free;
	assign req_accept = req_valid && req_ready;
	assign cfg_ready  = 1'b1;

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// decode the incoming item
	assign is_sample     = (req.req_type == tsa_pkg::REQ_SAMPLE);
	assign is_store      = is_sample && (req.sample_channel != tsa_pkg::CH_OTHER);
	assign axis_new      = is_store ? req.sample_channel : tsa_pkg::CH_X;
	assign pos_cur       = pos_q[axis_new];
	assign sample_masked = req.sample_value & SAMPLE_MASK;
	assign tick_fire     = (tick_count_q >= tick_limit_q);

	always_comb begin
		st_new               = '0;
		st_new.store         = is_store;
		st_new.axis          = axis_new;
		st_new.addr          = ADDR_W'(int'(axis_new) * RING_DEPTH) + ADDR_W'(pos_cur);
		st_new.sample        = SAMPLE_BITS'(sample_masked);
		st_new.wrap          = is_sample && (step_q == tsa_pkg::LAST_STEP);
		st_new.start_request = !is_sample && tick_fire;
		st_new.start_channel = (!is_sample && tick_fire) ? step_q : tsa_pkg::CH_X;
		st_new.calibrated    = calibrated_q || st_new.wrap;
		st_new.below_alarm   = is_sample && (sample_masked < alarm_threshold_q);
	end

	// ring storage: read at accept, write back when the item leaves stage 1
	tsa_ring_mem #(
		.DEPTH (NUM_ENTRIES),
		.WIDTH (SAMPLE_BITS)
	) u_ring_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_accept && is_store),
		.rd_addr (st_new.addr),
		.rd_data (old_sample),
		.wr_en   (s1_adv && st_s1.store),
		.wr_addr (st_s1.addr),
		.wr_data (st_s1.sample)
	);

	// drop the oldest sample, add the new one
	assign sum_upd = sum_q[st_s1.axis] - SUM_W'(old_sample) + SUM_W'(st_s1.sample);

	// means from the sums, which already include the item in stage 2
	always_comb begin
		for (int a = 0; a < tsa_pkg::NUM_AXES; a++) begin
			prod[a]     = PROD_W'(sum_q[a]) * PROD_W'(MUL_M);
			mean_new[a] = VALUE_W'(prod[a] >> MUL_K);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_limit_q      <= tsa_pkg::TICK_LIMIT_RESET;
			alarm_threshold_q <= tsa_pkg::ALARM_THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsa_pkg::CFG_TICK_LIMIT: begin
					tick_limit_q <= cfg_data[TICK_W-1:0];
				end
				tsa_pkg::CFG_ALARM_THRESHOLD: begin
					alarm_threshold_q <= cfg_data[VALUE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// accept-time state: tick counter, step counter, ring positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			step_q       <= tsa_pkg::CH_X;
			calibrated_q <= 1'b0;
			for (int a = 0; a < tsa_pkg::NUM_AXES; a++) begin
				pos_q[a] <= '0;
			end
		end else if (req_accept) begin
			if (!is_sample) begin
				tick_count_q <= tick_fire ? '0 : tick_count_q + 1'b1;
			end else begin
				step_q <= st_new.wrap ? tsa_pkg::CH_X : step_q + 1'b1;
				if (st_new.wrap) begin
					calibrated_q <= 1'b1;
				end
				if (is_store) begin
					pos_q[axis_new] <= (int'(pos_cur) == RING_DEPTH - 1) ?
						'0 : pos_cur + 1'b1;
				end
			end
		end
	end

	// running sums and held means
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < tsa_pkg::NUM_AXES; a++) begin
				sum_q[a]  <= '0;
				mean_q[a] <= '0;
			end
		end else begin
			if (s1_adv && st_s1.store) begin
				sum_q[st_s1.axis] <= sum_upd;
			end
			if (s2_adv && st_s2.wrap) begin
				for (int a = 0; a < tsa_pkg::NUM_AXES; a++) begin
					mean_q[a] <= mean_new[a];
				end
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= req_accept;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// pipeline payload: hold while stalled
	always_ff @(posedge clk) begin
		if (req_accept) begin
			st_s1 <= st_new;
		end
		if (s1_adv) begin
			st_s2 <= st_s1;
		end
		if (s2_adv) begin
			rsp_q.start_request <= st_s2.start_request;
			rsp_q.start_channel <= st_s2.start_channel;
			rsp_q.avg_valid     <= st_s2.wrap;
			rsp_q.avg_x         <= st_s2.wrap ? mean_new[0] : mean_q[0];
			rsp_q.avg_y         <= st_s2.wrap ? mean_new[1] : mean_q[1];
			rsp_q.avg_z         <= st_s2.wrap ? mean_new[2] : mean_q[2];
			rsp_q.calibrated    <= st_s2.calibrated;
			rsp_q.below_alarm   <= st_s2.below_alarm;
		end
	end

	// a ring entry is never read in the cycle it is written back
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_accept && is_store && s1_adv && st_s1.store) |-> (st_new.addr != st_s1.addr))
		else $error("ring read and write-back collide on one entry");

	// a stalled stage keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_free) |=> valid_s2)
		else $error("stage 2 item dropped while stalled");

	// fresh means always come with the calibrated flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.avg_valid) |-> rsp.calibrated)
		else $error("means refreshed without calibrated");

	// calibration never clears once set
	assert property (@(posedge clk) disable iff (!arst_n)
		calibrated_q |=> calibrated_q)
		else $error("calibrated flag fell");

	// the step counter only walks x, y, z
	assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != tsa_pkg::CH_OTHER))
		else $error("step counter left the axis range");

endmodule

@@ rtl/tsa_ring_mem.sv @@
// Sample ring storage: one write port, one registered read port, per-entry valid bits.
module tsa_ring_mem #(
	parameter int DEPTH = 30,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic [DEPTH-1:0] valid_q;
	logic             rd_valid_q;

	// storage and read data: no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule
